@@ src/i2cmbs_pkg.sv @@
package i2cmbs_pkg;

    // command codes carried in the input tuser field
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_SACK  = 3'd5;
    localparam logic [2:0] OP_RACK  = 3'd6;

    localparam logic [2:0] CMD_IDLE = 3'd0;

    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [7:0] PHASE_TICKS_RST = 8'd10;

    // one classified input transaction as held in the queue
    typedef struct packed {
        logic       is_cmd;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_bit;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

    // index of the final pin phase of each command
    function automatic logic [4:0] last_phase(input logic [2:0] cmd);
        logic [4:0] res;
        case (cmd)
            OP_START: res = 5'd3;
            OP_STOP:  res = 5'd2;
            OP_WRITE: res = 5'd23;
            OP_READ:  res = 5'd24;
            OP_SACK:  res = 5'd2;
            OP_RACK:  res = 5'd3;
            default:  res = 5'd0;
        endcase
        return res;
    endfunction

endpackage

@@ src/i2cmbs_front.sv @@
module i2cmbs_front (
    input  logic                              i_s_valid,
    output logic                              o_s_ready,
    input  logic [i2cmbs_pkg::IN_DATA_W-1:0]  i_s_data,
    input  logic [i2cmbs_pkg::IN_USER_W-1:0]  i_s_user,
    input  i2cmbs_pkg::t_q_stat               i_q_stat,
    output logic                              o_push,
    output i2cmbs_pkg::t_item                 o_item
);
    import i2cmbs_pkg::*;

    logic [2:0] op;

    assign op = i_s_user;

    assign o_s_ready = !i_q_stat.full;
    assign o_push    = i_s_valid && !i_q_stat.full;

    // reserved op code falls through as a plain tick
    always_comb begin
        o_item.op      = op;
        o_item.tx_byte = i_s_data[7:0];
        o_item.ack_bit = i_s_data[8];
        o_item.sda_in  = i_s_data[9];
        case (op)
            OP_START, OP_STOP, OP_WRITE, OP_READ, OP_SACK, OP_RACK: begin
                o_item.is_cmd = 1'b1;
            end
            default: begin
                o_item.is_cmd = 1'b0;
            end
        endcase
    end

endmodule

@@ src/i2cmbs_queue.sv @@
module i2cmbs_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cmbs_pkg::t_item   i_item,
    input  logic                i_pop,
    output i2cmbs_pkg::t_item   o_item,
    output i2cmbs_pkg::t_q_stat o_stat
);
    import i2cmbs_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push, do_pop;

    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.not_empty = (r_count != '0);
    assign o_item           = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_stat.not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ src/i2cmbs_back.sv @@
module i2cmbs_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [7:0]                         i_phase_ticks,
    input  i2cmbs_pkg::t_q_stat                i_q_stat,
    input  i2cmbs_pkg::t_item                  i_item,
    output logic                               o_pop,
    output logic                               o_m_valid,
    input  logic                               i_m_ready,
    output logic [i2cmbs_pkg::OUT_DATA_W-1:0]  o_m_data
);
    import i2cmbs_pkg::*;

    logic [2:0] r_cmd, n_cmd;
    logic [4:0] r_phase, n_phase;
    logic [1:0] r_sub, n_sub;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_shift, n_shift;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;
    logic [7:0] r_rx, n_rx;
    logic       r_ack, n_ack;
    logic       n_done, n_err;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [7:0] ticks;
    logic [8:0] tick_inc;

    assign ticks    = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
    assign tick_inc = {1'b0, r_tick} + 9'd1;

    assign o_pop     = i_q_stat.not_empty && (!r_out_valid || i_m_ready);
    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

    always_comb begin
        n_cmd   = r_cmd;
        n_phase = r_phase;
        n_sub   = r_sub;
        n_tick  = r_tick;
        n_shift = r_shift;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_ack   = r_ack;
        n_done  = 1'b0;
        n_err   = 1'b0;

        if (r_cmd == CMD_IDLE) begin
            if (i_item.is_cmd) begin
                n_cmd   = i_item.op;
                n_phase = '0;
                n_sub   = '0;
                n_tick  = '0;
                case (i_item.op)
                    OP_WRITE: n_shift = i_item.tx_byte;
                    OP_SACK:  n_shift = {7'd0, i_item.ack_bit};
                    default:  n_shift = '0;
                endcase
            end
        end else if (i_item.is_cmd) begin
            n_err = 1'b1;
        end else begin
            // pin action happens on the first tick of each phase
            if (r_tick == 8'd0) begin
                case (r_cmd)
                    OP_START: begin
                        case (r_phase)
                            5'd0:    n_sda = 1'b1;
                            5'd1:    n_scl = 1'b1;
                            5'd2:    n_sda = 1'b0;
                            default: n_scl = 1'b0;
                        endcase
                    end
                    OP_STOP: begin
                        case (r_phase)
                            5'd0:    n_sda = 1'b0;
                            5'd1:    n_scl = 1'b1;
                            default: n_sda = 1'b1;
                        endcase
                    end
                    OP_WRITE: begin
                        case (r_sub)
                            2'd0: begin
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                            end
                            2'd1:    n_scl = 1'b1;
                            default: n_scl = 1'b0;
                        endcase
                    end
                    OP_READ: begin
                        if (r_phase == 5'd0) begin
                            n_sda = 1'b1;
                        end else begin
                            case (r_sub)
                                2'd0:    n_scl   = 1'b1;
                                2'd1:    n_shift = {r_shift[6:0], i_item.sda_in};
                                default: n_scl   = 1'b0;
                            endcase
                        end
                    end
                    OP_SACK: begin
                        case (r_phase)
                            5'd0:    n_sda = r_shift[0];
                            5'd1:    n_scl = 1'b1;
                            default: n_scl = 1'b0;
                        endcase
                    end
                    OP_RACK: begin
                        case (r_phase)
                            5'd0:    n_sda = 1'b1;
                            5'd1:    n_scl = 1'b1;
                            5'd2:    n_ack = i_item.sda_in;
                            default: n_scl = 1'b0;
                        endcase
                    end
                    default: begin
                        n_scl = r_scl;
                    end
                endcase
            end

            if (tick_inc >= {1'b0, ticks}) begin
                n_tick  = '0;
                n_phase = r_phase + 5'd1;
                // read byte has a lone release phase before its bit triplets
                if (r_cmd == OP_READ && r_phase == 5'd0) begin
                    n_sub = '0;
                end else begin
                    n_sub = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;
                end
                if (r_phase >= last_phase(r_cmd)) begin
                    if (r_cmd == OP_READ) begin
                        n_rx = n_shift;
                    end
                    n_cmd   = CMD_IDLE;
                    n_phase = '0;
                    n_done  = 1'b1;
                end
            end else begin
                n_tick = tick_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= CMD_IDLE;
            r_phase     <= '0;
            r_sub       <= '0;
            r_tick      <= '0;
            r_shift     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= '0;
            r_ack       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd   <= n_cmd;
                r_phase <= n_phase;
                r_sub   <= n_sub;
                r_tick  <= n_tick;
                r_shift <= n_shift;
                r_scl   <= n_scl;
                r_sda   <= n_sda;
                r_rx    <= n_rx;
                r_ack   <= n_ack;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= {2'b00, n_err, n_ack, n_rx, n_done,
                           (n_cmd != CMD_IDLE), n_sda, n_scl};
        end
    end

endmodule

@@ src/i2c_master_bit_sequencer_unit.sv @@
// I2C master bit engine. Each input transaction carries a command or a tick in
// tuser; a command latches, and every following tick walks the pin phases
// (start, stop, write byte, read byte, send ack, read ack), each phase lasting
// phase_ticks ticks, with SCL/SDA drive levels (1 = released) reported in
// every result. Exactly one result is produced per input transaction. The
// unit sustains one transaction per clock while the output side is not
// stalled. An accepted transaction passes through the queue, and its result
// is registered in the back end's output register before it is valid. A
// command arriving while a sequence is running is dropped and flagged as an
// error. phase_ticks sits at byte address 0 of the register port and should
// only be written while no transaction is outstanding.
module i2c_master_bit_sequencer_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] tx_byte, [8] ack_bit, [9] sda_in, [15:10] zero
    input  logic [15:0] i_s_axis_tdata,
    // [2:0] op
    input  logic [2:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
    // [12] ack_in, [13] error, [15:14] zero
    output logic [15:0] o_m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cmbs_pkg::*;

    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;

    logic [7:0] r_phase_ticks;
    t_item      front_item, head_item;
    t_q_stat    q_stat;
    logic       push, pop;

    assign pready = 1'b1;
    assign prdata = (paddr[3:2] == REG_PHASE_TICKS) ? {24'd0, r_phase_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr[3:2] == REG_PHASE_TICKS) begin
            r_phase_ticks <= pwdata[7:0];
        end
    end

    i2cmbs_front u_front (
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_data  (i_s_axis_tdata),
        .i_s_user  (i_s_axis_tuser),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_item    (front_item)
    );

    i2cmbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    i2cmbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_phase_ticks (r_phase_ticks),
        .i_q_stat      (q_stat),
        .i_item        (head_item),
        .o_pop         (pop),
        .o_m_valid     (o_m_axis_tvalid),
        .i_m_ready     (i_m_axis_tready),
        .o_m_data      (o_m_axis_tdata)
    );

endmodule

@@ src/i2cmbs_checker.sv @@
module i2cmbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    // a stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a finished sequence leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |-> !o_m_axis_tdata[2])
        else $error("done reported while still busy");

    // a rejected command only happens during a running sequence
    a_err_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[13] |-> o_m_axis_tdata[2])
        else $error("error reported while idle");

    // a rejected command cannot also complete a sequence
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[13] && o_m_axis_tdata[3]))
        else $error("error and done in one result");

endmodule

bind i2c_master_bit_sequencer_unit i2cmbs_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
